FILE: design/ultrasonic_echo_ranger_macros.svh
// Assertion macros for the ultrasonic echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UER_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uer assertion failed");

// Next-cycle implication, disabled during reset.
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uer assertion failed");

`endif

FILE: design/uer_pkg.sv
// Types and constants shared by the ultrasonic echo ranger files.
package uer_pkg;

  localparam int TRIG_W   = 8;
  localparam int TICK_W   = 17;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID_TICKS = 2'd3;

  // reset values
  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST   = 8'd15;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST   = 17'd50000;
  localparam logic [TICK_W-1:0] MIN_VALID_TICKS_RST = 17'd200;
  localparam logic [TICK_W-1:0] MAX_VALID_TICKS_RST = 17'd40000;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RESPONSE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STUCK_HIGH   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_FALL = 4'b1000
  } phase_t;

endpackage

FILE: design/uer_if.sv
// Request and result channel interfaces of the ultrasonic echo ranger.
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if;
  import uer_pkg::*;
  logic                valid;
  logic                ready;
  logic                trig_level;
  logic                busy_res;
  logic                done_res;
  logic [TICK_W-1:0]   echo_ticks;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output trig_level, output busy_res, output done_res,
                  output echo_ticks, output status, input ready);
  modport sink   (input valid, input trig_level, input busy_res, input done_res,
                  input echo_ticks, input status, output ready);
endinterface

FILE: design/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: trigger pulse and echo width measurement.
//
// Usage:
//   in_ch  carries one request per 1 us tick: start_req and the sampled
//          echo_level. Every accepted request yields exactly one result.
//   out_ch carries trig_level, busy_res, done_res, echo_ticks and status.
//   cfg_we/cfg_idx/cfg_data write the four limit registers; write them
//   only while no measurement is running and no result is pending.
// Result: registered; it appears in the cycle after its request is accepted.
// Throughput: one request per cycle while out_ch does not stall; the phase/elapsed update and the
//   result are computed in one pass and land in the result register.
// Stall: in_ch.ready stays high while the result register is empty or
//   being drained this cycle; when out_ch stalls, the held result blocks
//   the next request, and nothing is dropped.
// Reset: phase returns to idle, elapsed to zero, registers to their
//   defaults (trigger 15, timeout 50000, min 200, max 40000), and the
//   result register is emptied.
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger (
  input  logic                          clk,
  input  logic                          rst,
  uer_in_if.sink                        in_ch,
  uer_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uer_pkg::*;

  logic [TRIG_W-1:0] trigger_ticks;
  logic [TICK_W-1:0] timeout_ticks;
  logic [TICK_W-1:0] min_valid_ticks;
  logic [TICK_W-1:0] max_valid_ticks;

  phase_t            phase, phase_next;
  logic [TICK_W-1:0] elapsed, elapsed_next;
  logic [TICK_W:0]   elapsed_inc;

  logic                trig_c, done_c;
  logic [TICK_W-1:0]   width_c;
  logic [STATUS_W-1:0] status_c;

  logic out_valid;
  logic in_accept;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks   <= TRIGGER_TICKS_RST;
      timeout_ticks   <= TIMEOUT_TICKS_RST;
      min_valid_ticks <= MIN_VALID_TICKS_RST;
      max_valid_ticks <= MAX_VALID_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TRIGGER_TICKS:   trigger_ticks   <= cfg_data[TRIG_W-1:0];
        REG_TIMEOUT_TICKS:   timeout_ticks   <= cfg_data[TICK_W-1:0];
        REG_MIN_VALID_TICKS: min_valid_ticks <= cfg_data[TICK_W-1:0];
        REG_MAX_VALID_TICKS: max_valid_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // elapsed never exceeds timeout in the waits, so one extra bit covers +1
  assign elapsed_inc = {1'b0, elapsed} + {{TICK_W{1'b0}}, 1'b1};

  always_comb begin
    phase_next   = phase;
    elapsed_next = elapsed;
    trig_c       = 1'b0;
    done_c       = 1'b0;
    width_c      = '0;
    status_c     = ST_OK;
    case (phase)
      PH_IDLE: begin
        if (in_ch.start_req) begin
          trig_c = 1'b1;
          // start tick counts as trigger tick one; zero length acts as one
          if (trigger_ticks <= {{(TRIG_W-1){1'b0}}, 1'b1}) begin
            phase_next   = PH_RISE;
            elapsed_next = '0;
          end else begin
            phase_next   = PH_TRIG;
            elapsed_next = {{(TICK_W-1){1'b0}}, 1'b1};
          end
        end
      end
      PH_TRIG: begin
        trig_c       = 1'b1;
        elapsed_next = elapsed_inc[TICK_W-1:0];
        if (elapsed_inc[TICK_W-1:0] >= {{(TICK_W-TRIG_W){1'b0}}, trigger_ticks}) begin
          phase_next   = PH_RISE;
          elapsed_next = '0;
        end
      end
      PH_RISE: begin
        if (in_ch.echo_level) begin
          phase_next   = PH_FALL;
          elapsed_next = {{(TICK_W-1){1'b0}}, 1'b1};
        end else if (elapsed_inc > {1'b0, timeout_ticks}) begin
          done_c       = 1'b1;
          status_c     = ST_NO_RESPONSE;
          phase_next   = PH_IDLE;
          elapsed_next = '0;
        end else begin
          elapsed_next = elapsed_inc[TICK_W-1:0];
        end
      end
      PH_FALL: begin
        if (in_ch.echo_level) begin
          if (elapsed_inc > {1'b0, timeout_ticks}) begin
            done_c       = 1'b1;
            status_c     = ST_STUCK_HIGH;
            phase_next   = PH_IDLE;
            elapsed_next = '0;
          end else begin
            elapsed_next = elapsed_inc[TICK_W-1:0];
          end
        end else begin
          done_c       = 1'b1;
          width_c      = elapsed;
          status_c     = (elapsed > max_valid_ticks || elapsed < min_valid_ticks) ?
                         ST_OUT_OF_RANGE : ST_OK;
          phase_next   = PH_IDLE;
          elapsed_next = '0;
        end
      end
      default: begin
        phase_next   = PH_IDLE;
        elapsed_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      elapsed <= '0;
    end else if (in_accept) begin
      phase   <= phase_next;
      elapsed <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_ch.trig_level <= trig_c;
      out_ch.busy_res   <= (phase_next != PH_IDLE);
      out_ch.done_res   <= done_c;
      out_ch.echo_ticks <= width_c;
      out_ch.status     <= status_c;
    end
  end

  `UER_ASSERT_SAME(a_done_not_busy, clk, rst, out_valid && out_ch.done_res, !out_ch.busy_res)
  `UER_ASSERT_NEXT(a_request_gives_result, clk, rst, in_accept, out_valid)
  `UER_ASSERT_NEXT(a_idle_holds, clk, rst, in_accept && phase == PH_IDLE && !in_ch.start_req, phase == PH_IDLE)
  `UER_ASSERT_SAME(a_fall_counts, clk, rst, phase == PH_FALL, elapsed != '0)

endmodule
